// File: rtl/emaht_pkg.sv
`timescale 1ns / 1ps

package emaht_pkg;

    // field widths
    localparam int IDX_W   = 3;
    localparam int SCORE_W = 16;
    localparam int THR_W   = 15;
    localparam int DROP_W  = 4;
    localparam int SHIFT_W = 3;
    localparam int CNT_W   = 4;
    localparam int LVL_W   = 18;
    localparam int CFG_ADDR_W = 3;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    localparam int NUM_TRACKS_DEF = 8;

    // register reset values, Q2.14
    localparam logic [THR_W-1:0]   BASE_RST  = 15'd13107;
    localparam logic [THR_W-1:0]   PERS_RST  = 15'd0;
    localparam logic [THR_W-1:0]   FLOOR_RST = 15'd12616;
    localparam logic [THR_W-1:0]   CEIL_RST  = 15'd11960;
    localparam logic [DROP_W-1:0]  DROP_RST  = 4'd3;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 3'd2;

    // 0.03 and 0.02 in Q2.14
    localparam logic signed [LVL_W-1:0] CAP_MARGIN = 18'sd492;
    localparam logic signed [LVL_W-1:0] GAP_MARGIN = 18'sd328;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BASE  = 3'd0,
        REG_PERS  = 3'd1,
        REG_FLOOR = 3'd2,
        REG_CEIL  = 3'd3,
        REG_DROP  = 3'd4,
        REG_SHIFT = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic signed [SCORE_W-1:0] ema;
        logic                      known;
        logic [CNT_W-1:0]          below;
    } t_entry;

    typedef struct packed {
        logic signed [LVL_W-1:0] on_lvl;
        logic signed [LVL_W-1:0] off_lvl;
        logic [DROP_W-1:0]       drop;
        logic [SHIFT_W-1:0]      shift;
    } t_thr;

endpackage

// File: rtl/emaht_cfg.sv
`timescale 1ns / 1ps

module emaht_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [emaht_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [emaht_pkg::THR_W-1:0]      i_cfg_wdata,
    output emaht_pkg::t_thr                  o_thr
);
    import emaht_pkg::*;

    logic [THR_W-1:0]   r_base, r_pers, r_floor, r_ceil;
    logic [DROP_W-1:0]  r_drop;
    logic [SHIFT_W-1:0] r_shift;
    logic signed [LVL_W-1:0] r_on, r_off;
    logic signed [LVL_W-1:0] n_on, n_off;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RST;
            r_pers  <= PERS_RST;
            r_floor <= FLOOR_RST;
            r_ceil  <= CEIL_RST;
            r_drop  <= DROP_RST;
            r_shift <= SHIFT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_BASE:  r_base  <= i_cfg_wdata;
                REG_PERS:  r_pers  <= i_cfg_wdata;
                REG_FLOOR: r_floor <= i_cfg_wdata;
                REG_CEIL:  r_ceil  <= i_cfg_wdata;
                REG_DROP:  r_drop  <= i_cfg_wdata[DROP_W-1:0];
                REG_SHIFT: r_shift <= i_cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // enter and exit levels from the thresholds
    always_comb begin
        logic signed [LVL_W-1:0] base, pers, cap, eff, flr, ceil_l, on_m;
        base   = $signed({3'b000, r_base});
        pers   = (r_pers != '0) ? $signed({3'b000, r_pers}) : base;
        cap    = base + CAP_MARGIN;
        flr    = $signed({3'b000, r_floor});
        ceil_l = $signed({3'b000, r_ceil});
        eff    = (pers < cap) ? pers : cap;
        if (eff < base) begin
            eff = base;
        end
        n_on  = (flr > eff) ? flr : eff;
        on_m  = n_on - GAP_MARGIN;
        n_off = (ceil_l < on_m) ? ceil_l : on_m;
    end

    // levels registered from the threshold registers
    always_ff @(posedge i_clk) begin
        r_on  <= n_on;
        r_off <= n_off;
    end

    assign o_thr = '{on_lvl: r_on, off_lvl: r_off, drop: r_drop, shift: r_shift};

endmodule

// File: rtl/emaht_store.sv
`timescale 1ns / 1ps

module emaht_store #(
    parameter int NUM_TRACKS = emaht_pkg::NUM_TRACKS_DEF,
    parameter int TW = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [TW-1:0]     i_rd_idx,
    input  logic              i_wr_en,
    input  logic [TW-1:0]     i_wr_idx,
    input  emaht_pkg::t_entry i_wr_entry,
    output emaht_pkg::t_entry o_rd_entry
);
    import emaht_pkg::*;

    t_entry                r_mem [NUM_TRACKS];
    logic [NUM_TRACKS-1:0] r_vld;
    t_entry                r_rd_data;
    logic                  r_rd_vld;
    logic [TW-1:0]         r_rd_idx;
    logic                  r_lw_valid;
    logic [TW-1:0]         r_lw_idx;
    t_entry                r_lw_data;

    // track state memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
            r_rd_idx  <= i_rd_idx;
        end
    end

    // per-entry written flags, unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
            end
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
        end
    end

    // last write kept for forwarding over the read latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_lw_valid <= 1'b1;
        end
        if (i_wr_en) begin
            r_lw_idx  <= i_wr_idx;
            r_lw_data <= i_wr_entry;
        end
    end

    always_comb begin
        if (r_lw_valid && (r_lw_idx == r_rd_idx)) begin
            o_rd_entry = r_lw_data;
        end else if (r_rd_vld) begin
            o_rd_entry = r_rd_data;
        end else begin
            o_rd_entry = '0;
        end
    end

endmodule

// File: rtl/emaht_update.sv
`timescale 1ns / 1ps

module emaht_update (
    input  emaht_pkg::t_entry                     i_entry,
    input  logic signed [emaht_pkg::SCORE_W-1:0] i_sim,
    input  emaht_pkg::t_thr                       i_thr,
    output emaht_pkg::t_entry                     o_entry
);
    import emaht_pkg::*;

    logic                      fresh;
    logic signed [SCORE_W:0]   diff, step, sum;
    logic signed [SCORE_W-1:0] n_ema;
    logic signed [LVL_W-1:0]   ema_l;
    logic [CNT_W:0]            cnt;
    logic                      drop_now;

    // moving average, fresh track takes the sample
    always_comb begin
        fresh = (i_entry.ema == '0) && !i_entry.known && (i_entry.below == '0);
        diff  = $signed({i_sim[SCORE_W-1], i_sim}) -
                $signed({i_entry.ema[SCORE_W-1], i_entry.ema});
        step  = diff >>> i_thr.shift;
        sum   = $signed({i_entry.ema[SCORE_W-1], i_entry.ema}) + step;
        n_ema = fresh ? i_sim : sum[SCORE_W-1:0];
        ema_l = $signed({{(LVL_W-SCORE_W){n_ema[SCORE_W-1]}}, n_ema});
    end

    // hysteresis on the known flag
    always_comb begin
        cnt      = {1'b0, i_entry.below} + 1'b1;
        drop_now = (cnt >= {1'b0, i_thr.drop});
        o_entry  = '{ema: n_ema, known: i_entry.known, below: i_entry.below};
        if (!i_entry.known) begin
            if (ema_l >= i_thr.on_lvl) begin
                o_entry.known = 1'b1;
                o_entry.below = '0;
            end
        end else if (ema_l < i_thr.off_lvl) begin
            if (drop_now) begin
                o_entry.known = 1'b0;
                o_entry.below = '0;
            end else begin
                o_entry.below = cnt[CNT_W-1:0];
            end
        end else begin
            o_entry.below = '0;
        end
    end

endmodule

// File: rtl/ema_hysteresis_identity_tracker_top.sv
`timescale 1ns / 1ps

// Per-track score smoother with hysteresis. Each word on the slave side names a
// track and carries a Q2.14 similarity; the block updates that track's moving
// average and known flag and returns one word per input, in order. A new word
// is taken every cycle unless the update stage and output register are full
// and the master side holds off; a word passes the registered state memory
// read into the update stage, then the output register, the last write being
// forwarded so that back-to-back words on the same track see each other's
// update. Every track starts at zero after reset, no clearing pass.
// Configuration writes must only be made while no word is in flight.
module ema_hysteresis_identity_tracker_top #(
    parameter int NUM_TRACKS = emaht_pkg::NUM_TRACKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [2:0] track_index, [18:3] similarity, [23:19] zero
    input  logic [emaht_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [0] is_match, [16:1] smoothed_score, [23:17] zero
    output logic [emaht_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [emaht_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [emaht_pkg::THR_W-1:0]      i_cfg_wdata
);
    import emaht_pkg::*;

    localparam int TW = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;

    t_thr                      thr;
    t_entry                    rd_entry, upd_entry;
    logic                      accept, s1_adv;
    logic [TW-1:0]             n_idx;
    logic                      r_s1_valid;
    logic [TW-1:0]             r_s1_idx;
    logic signed [SCORE_W-1:0] r_s1_sim;
    logic                      r_out_valid;
    logic                      r_out_match;
    logic signed [SCORE_W-1:0] r_out_score;

    // raw track field folded onto the track count, a small constant table
    function automatic logic [TW-1:0] track_of(input logic [IDX_W-1:0] raw);
        logic [TW-1:0] res;
        res = '0;
        for (int v = 0; v < (1 << IDX_W); v++) begin
            if (raw == IDX_W'(v)) begin
                res = TW'(v % NUM_TRACKS);
            end
        end
        return res;
    endfunction

    // handshake
    assign s1_adv          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign n_idx = track_of(i_s_axis_tdata[IDX_W-1:0]);

    emaht_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_thr       (thr)
    );

    emaht_store #(
        .NUM_TRACKS (NUM_TRACKS),
        .TW         (TW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_idx   (n_idx),
        .i_wr_en    (r_s1_valid && s1_adv),
        .i_wr_idx   (r_s1_idx),
        .i_wr_entry (upd_entry),
        .o_rd_entry (rd_entry)
    );

    emaht_update u_update (
        .i_entry (rd_entry),
        .i_sim   (r_s1_sim),
        .i_thr   (thr),
        .o_entry (upd_entry)
    );

    // update stage, waits on the state read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (accept) begin
            r_s1_idx <= n_idx;
            r_s1_sim <= $signed(i_s_axis_tdata[IDX_W +: SCORE_W]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_match <= upd_entry.known;
            r_out_score <= upd_entry.ema;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W-SCORE_W-1)'(0), r_out_score, r_out_match};

endmodule

// File: rtl/emaht_checker.sv
`timescale 1ns / 1ps

module emaht_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [emaht_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready
);
    import emaht_pkg::*;

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // input side stalls only when both stages are full and blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output backpressure");

    // after an accepted word, output valid is raised behind the update stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> ##1 o_m_axis_tvalid)
        else $error("no result after accepted word");

    // pad bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[M_TDATA_W-1:SCORE_W+1] == '0)
        else $error("nonzero pad bits");

endmodule

bind ema_hysteresis_identity_tracker_top emaht_checker u_emaht_checker (.*);

// File: tb/sv/ema_hysteresis_identity_tracker_top_tb.sv
`timescale 1ns / 1ps

module ema_hysteresis_identity_tracker_top_tb;
    import emaht_pkg::*;

    localparam int TRACKS       = 8;
    localparam int LIMIT_CYCLES = 600000;
    localparam int LONG_HOLD    = 300;
    localparam int Q_ONE        = 16384;
    localparam int MAX_PRINTS   = 100;
    localparam int PHASE_ITEMS  = 72;

    // register slots past the last real one, writes there must change nothing
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE7 = 3'd7;

    typedef struct {
        logic                      known;
        logic signed [SCORE_W-1:0] score;
    } t_track_result;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic [S_TDATA_W-1:0]  s_data    = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [M_TDATA_W-1:0]  m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [THR_W-1:0]      cfg_wdata = '0;

    // predicted configuration and per-track state
    logic [THR_W-1:0]          base_thr;
    logic [THR_W-1:0]          pers_thr;
    logic [THR_W-1:0]          floor_lvl;
    logic [THR_W-1:0]          ceil_lvl;
    logic [DROP_W-1:0]         drop_need;
    logic [SHIFT_W-1:0]        ema_shift_q;
    logic signed [SCORE_W-1:0] trk_ema   [TRACKS];
    logic                      trk_known [TRACKS];
    logic [CNT_W-1:0]          trk_below [TRACKS];

    t_track_result pending_results[$];
    int            errors      = 0;
    int unsigned   cycle_count = 0;
    logic          no_idle     = 1'b0;
    int            stall_asked = 0;
    int            stall_done  = 0;
    int            ready_run   = 0;

    ema_hysteresis_identity_tracker_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** ema_hysteresis_identity_tracker_top: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch %s at cycle %0d: got %0h want %0h", what, cycle_count, got, want);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 48);
    endfunction

    task automatic model_reset();
        base_thr    = BASE_RST;
        pers_thr    = PERS_RST;
        floor_lvl   = FLOOR_RST;
        ceil_lvl    = CEIL_RST;
        drop_need   = DROP_RST;
        ema_shift_q = SHIFT_RST;
        for (int i = 0; i < TRACKS; i++) begin
            trk_ema[i]   = '0;
            trk_known[i] = 1'b0;
            trk_below[i] = '0;
        end
    endtask

    // enter and exit levels from the current thresholds
    function automatic void calc_levels(output int on_l, output int off_l);
        int base;
        int pers;
        int eff;
        base = int'(base_thr);
        pers = (pers_thr != '0) ? int'(pers_thr) : base;
        eff  = (pers < base + int'(CAP_MARGIN)) ? pers : base + int'(CAP_MARGIN);
        if (eff < base)
            eff = base;
        on_l  = (int'(floor_lvl) > eff) ? int'(floor_lvl) : eff;
        off_l = (int'(ceil_lvl) < on_l - int'(GAP_MARGIN)) ? int'(ceil_lvl)
                                                            : on_l - int'(GAP_MARGIN);
    endfunction

    // smooth one score into its track and apply the hysteresis
    function automatic t_track_result track_update(input logic [IDX_W-1:0] trk,
                                                   input logic signed [SCORE_W-1:0] sim);
        t_track_result res;
        int            cur;
        int            nxt;
        int            samp;
        int            on_l;
        int            off_l;
        int unsigned   cnt;
        samp = sim;
        cur  = trk_ema[trk];
        // an all-zero track takes the score as it is
        if (cur == 0 && trk_below[trk] == '0 && !trk_known[trk])
            nxt = samp;
        else
            nxt = cur + ((samp - cur) >>> ema_shift_q);
        trk_ema[trk] = nxt[SCORE_W-1:0];

        calc_levels(on_l, off_l);
        if (!trk_known[trk]) begin
            if (nxt >= on_l) begin
                trk_known[trk] = 1'b1;
                trk_below[trk] = '0;
            end
        end else if (nxt < off_l) begin
            cnt = trk_below[trk] + 1;
            if (cnt >= drop_need) begin
                trk_known[trk] = 1'b0;
                trk_below[trk] = '0;
            end else begin
                trk_below[trk] = cnt[CNT_W-1:0];
            end
        end else begin
            trk_below[trk] = '0;
        end

        res.known = trk_known[trk];
        res.score = nxt[SCORE_W-1:0];
        return res;
    endfunction

    // offer one word and wait until it is taken
    task automatic send_word(input logic [IDX_W-1:0] trk, input logic signed [SCORE_W-1:0] sim);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(S_TDATA_W-IDX_W-SCORE_W){1'b0}}, sim, trk};
        do @(posedge i_clk); while (!s_ready);
        pending_results.push_back(track_update(trk, sim));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [THR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_BASE:  base_thr    = val;
            REG_PERS:  pers_thr    = val;
            REG_FLOOR: floor_lvl   = val;
            REG_CEIL:  ceil_lvl    = val;
            REG_DROP:  drop_need   = val[DROP_W-1:0];
            REG_SHIFT: ema_shift_q = val[SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    // drain, write every register, the spare slots too, then let the block settle
    task automatic load_settings(input logic [THR_W-1:0] b, input logic [THR_W-1:0] p,
                                 input logic [THR_W-1:0] f, input logic [THR_W-1:0] c,
                                 input logic [THR_W-1:0] drop_w,
                                 input logic [THR_W-1:0] shift_w);
        wait_idle();
        write_reg(REG_BASE, b);
        write_reg(REG_PERS, p);
        write_reg(REG_SPARE6, THR_W'($urandom));
        write_reg(REG_FLOOR, f);
        write_reg(REG_CEIL, c);
        write_reg(REG_DROP, drop_w);
        write_reg(REG_SPARE7, THR_W'($urandom));
        write_reg(REG_SHIFT, shift_w);
        cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    // receiver: random stalls, or one long hold when asked
    always @(posedge i_clk) begin
        if (stall_asked != stall_done) begin
            stall_done = stall_asked;
            ready_run  = LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run--;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 9) < 6) begin
            m_ready  <= 1'b1;
            ready_run = $urandom_range(0, 7);
        end else begin
            m_ready  <= 1'b0;
            ready_run = pick_gap();
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_track_result want;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", 32'(m_data), '0);
            end else begin
                want = pending_results.pop_front();
                if (m_data[0] !== want.known)
                    report_mismatch("is_match", 32'(m_data[0]), 32'(want.known));
                if (m_data[SCORE_W:1] !== want.score)
                    report_mismatch("smoothed_score", 32'(m_data[SCORE_W:1]),
                                    32'(want.score[SCORE_W-1:0]));
                if (m_data[M_TDATA_W-1:SCORE_W+1] !== '0)
                    report_mismatch("padding", 32'(m_data[M_TDATA_W-1:SCORE_W+1]), '0);
            end
        end
    end

    // default thresholds straight out of reset: enter, three-sample drop, zero restart
    task automatic test_reset_defaults();
        send_word(3'd0, 16'sd16384);
        repeat (3) send_word(3'd0, -16'sd16384);
        send_word(3'd1, -16'sd16384);
        send_word(3'd7, -16'sd1);
        send_word(3'd2, 16'sd0);
        send_word(3'd2, 16'sd13107);
        wait_idle();
    endtask

    // drop count zero, unsmoothed average reaching zero, shift above four
    task automatic test_fast_drop();
        load_settings(BASE_RST, PERS_RST, FLOOR_RST, CEIL_RST, 15'd0, 15'd0);
        send_word(3'd4, 16'sd16384);
        send_word(3'd4, 16'sd0);
        send_word(3'd4, 16'sd5000);
        send_word(3'd3, 16'sd16383);
        load_settings(BASE_RST, PERS_RST, FLOOR_RST, CEIL_RST, 15'd1, 15'd5);
        send_word(3'd3, -16'sd16384);
        send_word(3'd3, 16'sd8191);
        wait_idle();
    endtask

    // personal threshold capped above base, and held up at base
    task automatic test_threshold_caps();
        load_settings(15'd0, 15'd16384, 15'd0, 15'd16384, 15'd15, 15'd7);
        send_word(3'd5, 16'sd400);
        send_word(3'd5, 16'sd16384);
        send_word(3'd5, -16'sd16384);
        load_settings(15'd16384, 15'd100, 15'd0, 15'd0, 15'd2, 15'd1);
        send_word(3'd6, 16'sd16384);
        repeat (3) send_word(3'd6, -16'sd16384);
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        stall_asked <= stall_asked + 1;
        no_idle     <= 1'b1;
        repeat (40) send_word(IDX_W'($urandom), SCORE_W'(int'($urandom_range(0, 2*Q_ONE)) - Q_ONE));
        no_idle <= 1'b0;
        wait_idle();
    endtask

    // one setting, then runs of scores per track steered around the levels
    task automatic test_random_phase(input int kind, input int n_items);
        logic [THR_W-1:0] b;
        logic [THR_W-1:0] p;
        logic [THR_W-1:0] f;
        logic [THR_W-1:0] c;
        logic [THR_W-1:0] drop_w;
        logic [THR_W-1:0] shift_w;
        int               tmp;
        int               on_l;
        int               off_l;
        int               left;
        int               mode;
        int               tgt;
        logic [IDX_W-1:0] trk;

        drop_w  = THR_W'($urandom);
        shift_w = THR_W'($urandom);
        case (kind)
            0: begin
                b = BASE_RST; p = PERS_RST; f = FLOOR_RST; c = CEIL_RST;
                drop_w[DROP_W-1:0]   = DROP_W'($urandom_range(1, 15));
                shift_w[SHIFT_W-1:0] = SHIFT_W'($urandom_range(0, 4));
            end
            1: begin
                b = THR_W'($urandom_range(9000, 15000));
                tmp = int'(b) + int'($urandom_range(0, 1800)) - 900;
                p = $urandom_range(0, 2) == 0 ? '0 : THR_W'(tmp);
                tmp = int'(b) - int'($urandom_range(0, 1200));
                f = THR_W'(tmp);
                tmp = int'(f) - int'($urandom_range(0, 1500));
                c = THR_W'(tmp);
                drop_w[DROP_W-1:0]   = DROP_W'($urandom_range(1, 6));
                shift_w[SHIFT_W-1:0] = SHIFT_W'($urandom_range(0, 3));
            end
            2: begin
                b = $urandom_range(0, 1) ? 15'd16384 : 15'd0;
                p = $urandom_range(0, 1) ? 15'd16384 : 15'd1;
                f = $urandom_range(0, 1) ? 15'd16384 : 15'd0;
                c = $urandom_range(0, 1) ? 15'd16384 : 15'd0;
                drop_w[DROP_W-1:0]   = $urandom_range(0, 1) ? 4'd15 : 4'd0;
                shift_w[SHIFT_W-1:0] = $urandom_range(0, 1) ? 3'd7 : 3'd0;
            end
            default: begin
                b = THR_W'($urandom_range(0, Q_ONE));
                p = THR_W'($urandom_range(0, Q_ONE));
                f = THR_W'($urandom_range(0, Q_ONE));
                c = THR_W'($urandom_range(0, Q_ONE));
                drop_w[DROP_W-1:0]   = DROP_W'($urandom_range(0, 15));
                shift_w[SHIFT_W-1:0] = SHIFT_W'($urandom_range(0, 7));
            end
        endcase
        load_settings(b, p, f, c, drop_w, shift_w);
        calc_levels(on_l, off_l);

        left = n_items;
        while (left > 0) begin
            trk  = IDX_W'($urandom);
            mode = $urandom_range(0, 9);
            repeat ($urandom_range(1, 12)) begin
                case (mode)
                    0, 1, 2: tgt = on_l + int'($urandom_range(0, 1500));
                    3, 4, 5: tgt = off_l - int'($urandom_range(0, 3000));
                    6:       tgt = on_l + int'($urandom_range(0, 800)) - 400;
                    7:       tgt = off_l + int'($urandom_range(0, 800)) - 400;
                    8:       tgt = int'($urandom_range(0, 2*Q_ONE)) - Q_ONE;
                    default: tgt = 0;
                endcase
                if (tgt > Q_ONE)  tgt = Q_ONE;
                if (tgt < -Q_ONE) tgt = -Q_ONE;
                send_word(trk, tgt[SCORE_W-1:0]);
                left--;
            end
        end
        wait_idle();
    endtask

    initial begin
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_fast_drop();
        test_threshold_caps();
        test_random_phase(0, PHASE_ITEMS);
        test_random_phase(1, PHASE_ITEMS);
        test_backpressure();
        test_random_phase(2, PHASE_ITEMS);
        test_random_phase(3, PHASE_ITEMS);
        no_idle <= 1'b1;
        test_random_phase(1, PHASE_ITEMS);
        no_idle <= 1'b0;
        test_random_phase(0, PHASE_ITEMS);
        test_random_phase(3, PHASE_ITEMS);
        test_random_phase(2, PHASE_ITEMS);
        test_random_phase(1, PHASE_ITEMS);
        test_random_phase(3, PHASE_ITEMS);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("** ema_hysteresis_identity_tracker_top: PASSED **");
        end else begin
            $display("** ema_hysteresis_identity_tracker_top: FAILED **");
        end
        $finish;
    end

endmodule
